@@ rtl/btra_pkg.sv @@
package btra_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int MAX_DIGITS_DEF  = 64;

	localparam int RADIX_W  = 6;
	localparam int DIGIT_W  = 6;
	localparam int CHAR_W   = 7;
	localparam int COUNT_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [DIGIT_W-1:0] DEC_BASE   = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;

	// controller -> datapath
	typedef struct packed {
		logic load;      // take a new value, clear count and remainder
		logic step;      // one restoring-division bit
		logic wr;        // store remainder as next digit
		logic rd_init;   // point read index at the most significant digit
		logic rd_dec;    // move to the next lower digit
		logic load_out;  // fill the output register
		logic cfg_wr;    // radix write
	} btra_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_bit;  // final division step of this digit
		logic q_zero;    // quotient exhausted
		logic full;      // digit store about to be full
		logic rd_zero;   // reading the least significant digit
	} btra_st_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {1'b0, d};
		if (d < DEC_BASE)
			return ASCII_ZERO + ext;
		else
			return ASCII_A + ext - {1'b0, DEC_BASE};
	endfunction

endpackage

@@ rtl/btra_ram.sv @@
module btra_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/btra_dp.sv @@
module btra_dp #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  btra_pkg::btra_cmd_t               cmd,
	output btra_pkg::btra_st_t                st,
	input  logic [63:0]                       value,
	input  logic [btra_pkg::RADIX_W-1:0]      radix,
	output logic [btra_pkg::CHAR_W-1:0]       digit_char,
	output logic                              is_last,
	output logic [btra_pkg::COUNT_W-1:0]      digit_count
);
	import btra_pkg::*;

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int BW = $clog2(VALUE_WIDTH);

	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [BW-1:0]          bit_q;
	logic [COUNT_W-1:0]     ndig_q;
	logic [AW-1:0]          rd_idx_q;

	logic [DIGIT_W:0]       rem_sh;
	logic                   fits;
	logic [DIGIT_W:0]       rem_sub;
	logic [RADIX_W-1:0]     radix_clamped;
	logic [DIGIT_W-1:0]     rd_digit;

	always_comb begin
		if (radix < RADIX_MIN)
			radix_clamped = RADIX_MIN;
		else if (radix > RADIX_MAX)
			radix_clamped = RADIX_MAX;
		else
			radix_clamped = radix;
	end

	// one bit of restoring division
	assign rem_sh  = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign fits    = rem_sh >= {1'b0, radix_q};
	assign rem_sub = rem_sh - {1'b0, radix_q};

	assign st.last_bit = bit_q == BW'(VALUE_WIDTH - 1);
	assign st.q_zero   = quo_q == '0;
	assign st.full     = ndig_q == COUNT_W'(MAX_DIGITS - 1);
	assign st.rd_zero  = rd_idx_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			quo_q   <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			ndig_q  <= '0;
		end else begin
			if (cmd.cfg_wr)
				radix_q <= radix_clamped;
			if (cmd.load) begin
				quo_q  <= value[VALUE_WIDTH-1:0];
				rem_q  <= '0;
				bit_q  <= '0;
				ndig_q <= '0;
			end else if (cmd.step) begin
				quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
				rem_q <= fits ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
				bit_q <= bit_q + BW'(1);
			end else if (cmd.wr) begin
				rem_q  <= '0;
				bit_q  <= '0;
				ndig_q <= ndig_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_init)
			rd_idx_q <= ndig_q[AW-1:0];
		else if (cmd.rd_dec)
			rd_idx_q <= rd_idx_q - AW'(1);
		if (cmd.load_out) begin
			digit_char  <= digit_to_ascii(rd_digit);
			is_last     <= st.rd_zero;
			digit_count <= ndig_q;
		end
	end

	btra_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(ndig_q[AW-1:0]),
		.wdata(rem_q),
		.raddr(rd_idx_q),
		.rdata(rd_digit)
	);

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < radix_q) else $error("remainder not below radix");
	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		radix_q >= RADIX_MIN && radix_q <= RADIX_MAX) else $error("radix out of range");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= COUNT_W'(MAX_DIGITS)) else $error("digit count overflow");
endmodule

@@ rtl/btra_ctrl.sv @@
module btra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	output btra_pkg::btra_cmd_t  cmd,
	input  btra_pkg::btra_st_t   st
);
	import btra_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WR,
		S_RD,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   in_acc;

	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.cfg_wr   = cfg_valid;
		cmd.load     = in_acc;
		cmd.step     = state_q == S_DIV;
		cmd.wr       = state_q == S_WR;
		cmd.rd_init  = state_q == S_WR && (st.q_zero || st.full);
		cmd.load_out = state_q == S_EMIT && slot_free;
		cmd.rd_dec   = cmd.load_out && !st.rd_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (st.last_bit)
						state_q <= S_WR;
				end
				S_WR: begin
					state_q <= (st.q_zero || st.full) ? S_RD : S_DIV;
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free)
						state_q <= st.rd_zero ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_DIV) else $error("accept did not start division");
	a_div_to_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && st.last_bit |=> state_q == S_WR) else $error("digit not stored");
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall)) else $error("output overwritten");
endmodule

@@ rtl/binary_to_radix_ascii_top.sv @@
// Integer to ASCII conversion, radix 2..36, digits emitted most significant first.
// Each digit comes from the bit-serial divider and goes into the digit store; the
// digits are then read back from the store into the output register. A new value
// is accepted only once the last digit of the previous one has been emitted.
// Reset: arst_n async active low; radix returns to 10, no beat pending.
module binary_to_radix_ascii_top #(
	parameter int VALUE_WIDTH = btra_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = btra_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beat
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [63:0]                   value,
	// result beat, one per digit
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [btra_pkg::CHAR_W-1:0]   digit_char,
	output logic                          is_last,
	output logic [btra_pkg::COUNT_W-1:0]  digit_count,
	// radix register write, clamped to 2..36
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [btra_pkg::RADIX_W-1:0]  radix
);
	import btra_pkg::*;

	btra_cmd_t cmd;
	btra_st_t  st;

	// Controller: idle -> divide (one quotient bit per cycle) -> store digit,
	// looping until the quotient is zero or the store is full; then read back
	// from the top digit down, one beat per digit.
	btra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cmd      (cmd),
		.st       (st)
	);

	// Datapath: radix register, restoring divider, digit store, output register.
	btra_dp #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.value      (value),
		.radix      (radix),
		.digit_char (digit_char),
		.is_last    (is_last),
		.digit_count(digit_count)
	);
endmodule

@@ bench/binary_to_radix_ascii_top_tb.sv @@
`timescale 1ns / 1ps

module binary_to_radix_ascii_top_tb;
	import btra_pkg::*;

	// Longest stretch with no beat on any channel before we call it hung.
	// It must cover a 64-digit radix-2 conversion before its first digit,
	// and must also outlast the forced receiver hold.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 2000;
	localparam int DIGIT_CAP      = MAX_DIGITS_DEF;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic               last;
		logic [COUNT_W-1:0] count;
	} digit_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [63:0]        value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CHAR_W-1:0]  digit_char;
	logic               is_last;
	logic [COUNT_W-1:0] digit_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [RADIX_W-1:0] radix = '0;

	binary_to_radix_ascii_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digit_char  (digit_char),
		.is_last     (is_last),
		.digit_count (digit_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.radix       (radix)
	);

	// Values waiting to be sent, filled by the sequence below, drained by the driver.
	logic [63:0] values_waiting [$];
	// Digits predicted but not yet seen on the output, oldest first.
	digit_beat_t digits_due [$];

	// Our own copy of the radix register, updated on each config beat.
	logic [RADIX_W-1:0] base_now = RADIX_RESET;

	int  bad_digits   = 0;
	int  quiet_cycles = 0;
	bit  in_taken     = 1'b0;   // input beat accepted at the last rising edge
	bit  idle_on      = 1'b0;   // random gaps/stalls enabled
	int  send_gap     = 0;
	int  stall_left   = 0;
	int  hold_left    = 0;
	int  holds_asked  = 0;
	int  holds_served = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps, some medium, a few long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 15);
		else
			return $urandom_range(40, 150);
	endfunction

	// Writes to the radix register land clamped into 2..36; only 6 bits reach the port.
	function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] w);
		if (w < RADIX_MIN)
			return RADIX_MIN;
		if (w > RADIX_MAX)
			return RADIX_MAX;
		return w;
	endfunction

	// Repeated division by the current base; remainders come out least
	// significant first, digits go out most significant first. Collection
	// stops at DIGIT_CAP, which a 64-bit value reaches only in radix 2, at most.
	task automatic expect_digits(input logic [63:0] v);
		logic [DIGIT_W-1:0] rems [DIGIT_CAP];
		logic [63:0]        q;
		int                 n;
		digit_beat_t        b;
		q = v;
		n = 0;
		do begin
			rems[n] = DIGIT_W'(q % 64'(base_now));
			q = q / 64'(base_now);
			n++;
		end while (q != 0 && n < DIGIT_CAP);
		for (int k = n - 1; k >= 0; k--) begin
			if (rems[k] < DEC_BASE)
				b.ch = ASCII_ZERO + CHAR_W'(rems[k]);
			else
				b.ch = ASCII_A + CHAR_W'(rems[k] - DEC_BASE);
			b.last  = (k == 0);
			b.count = COUNT_W'(n);
			digits_due.push_back(b);
		end
	endtask

	// Driver: holds a beat while stalled, otherwise inserts a gap or takes
	// the next pending value. Every signal gets one assignment per edge.
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// stalled: payload stays put
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (values_waiting.size() > 0) begin
			value    <= values_waiting.pop_front();
			in_valid <= 1'b1;
			send_gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: a requested long hold wins, then random stall bursts.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (holds_served < holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = idle_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: samples all channels at the rising edge, predicts on input
	// beats, checks output beats against the oldest prediction, and runs
	// the watchdog.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken     = 1'b0;
			quiet_cycles = 0;
		end else begin
			in_taken = in_valid && !in_stall;
			if (cfg_valid && cfg_ready)
				base_now = clamp_base(radix);
			if (in_taken)
				expect_digits(value);
			if (out_valid && !out_stall) begin
				if (digits_due.size() == 0) begin
					$error("unexpected digit beat: digit_char %0h is_last %0b digit_count %0d",
						digit_char, is_last, digit_count);
					bad_digits++;
				end else begin
					digit_beat_t exp_b;
					exp_b = digits_due.pop_front();
					if (digit_char !== exp_b.ch) begin
						$error("digit_char: expected %0h, got %0h", exp_b.ch, digit_char);
						bad_digits++;
					end
					if (is_last !== exp_b.last) begin
						$error("is_last: expected %0b, got %0b", exp_b.last, is_last);
						bad_digits++;
					end
					if (digit_count !== exp_b.count) begin
						$error("digit_count: expected %0d, got %0d", exp_b.count, digit_count);
						bad_digits++;
					end
				end
			end
			if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Block is idle once nothing is queued, offered or outstanding.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (values_waiting.size() != 0 || in_valid || digits_due.size() != 0);
	endtask

	// Radix write; only issued while idle.
	task automatic write_radix(input logic [RADIX_W-1:0] w);
		wait_idle();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		radix     <= w;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random values of random bit length, so short and long conversions mix.
	task automatic queue_random(input int count, input int max_bits);
		logic [63:0] v;
		int          w;
		for (int i = 0; i < count; i++) begin
			@(posedge clk);
			v = {$urandom(), $urandom()};
			w = $urandom_range(1, max_bits);
			if (w < 64 && $urandom_range(0, 4) != 0)
				v = v & ((64'd1 << w) - 64'd1);
			values_waiting.push_back(v);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default radix 10 straight out of reset: zero, single digit, digit
		// rollover, full-scale and alternating bit patterns.
		values_waiting.push_back(64'd0);
		values_waiting.push_back(64'd1);
		values_waiting.push_back(64'd9);
		values_waiting.push_back(64'd10);
		values_waiting.push_back(64'd100);
		values_waiting.push_back('1);
		values_waiting.push_back(64'h8000_0000_0000_0000);
		values_waiting.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		values_waiting.push_back(64'h5555_5555_5555_5555);

		// Write of 0 clamps to 2: full-scale gives the 64-digit maximum.
		write_radix(6'd0);
		values_waiting.push_back(64'd0);
		values_waiting.push_back(64'd2);
		values_waiting.push_back('1);
		values_waiting.push_back(64'h8000_0000_0000_0000);

		// All ones on the port clamps to 36: digits run up to 'Z'.
		write_radix(6'd63);
		values_waiting.push_back(64'd35);
		values_waiting.push_back(64'd36);
		values_waiting.push_back(64'd1295);
		values_waiting.push_back('1);

		// Just outside the range at both ends.
		write_radix(6'd1);
		values_waiting.push_back(64'd5);
		write_radix(6'd37);
		values_waiting.push_back(64'd46655);
		write_radix(6'd16);
		values_waiting.push_back(64'hDEAD_BEEF);
		values_waiting.push_back(64'd15);

		// Random part, gaps and stalls on.
		idle_on = 1'b1;
		write_radix(6'd10);
		queue_random(40, 64);
		write_radix(6'd2);
		queue_random(15, 64);
		// a calm stretch at the top radix
		idle_on = 1'b0;
		write_radix(6'd36);
		queue_random(30, 64);

		// Long receiver hold while the sender keeps offering short values,
		// so the output backs up and the input stalls.
		write_radix(6'd16);
		@(posedge clk);
		holds_asked++;
		for (int i = 0; i < 10; i++) begin
			@(posedge clk);
			values_waiting.push_back(64'($urandom_range(0, 255)));
		end
		idle_on = 1'b1;
		queue_random(30, 64);
		// sender pause: nothing more until every digit is back
		wait_idle();
		queue_random(30, 40);

		// A few random radix settings, any 6-bit write.
		for (int p = 0; p < 5; p++) begin
			write_radix(RADIX_W'($urandom_range(0, 63)));
			queue_random(20, 64);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_digits == 0 && digits_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/btra_pkg.sv
rtl/btra_ram.sv
rtl/btra_dp.sv
rtl/btra_ctrl.sv
rtl/binary_to_radix_ascii_top.sv
bench/binary_to_radix_ascii_top_tb.sv
